/* rtl/mexp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// shared widths and types for the modular exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;
  localparam int unsigned WIDTH = 64;
  localparam int unsigned FIELD_W = 64;
  localparam int unsigned CNT_W = $clog2(WIDTH + 1);
  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;
endpackage

/* rtl/modular_exponentiation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation
// right-to-left binary square-and-multiply modular exponentiation
// ----------------------------------------------------------------------------
// usage:
//   a request on the in_ channel (in_valid/in_ready) brings base, exponent
//   and modulus; the out_ channel (out_valid/out_ready) returns power_result
//   and modulus_zero_error, one result per request, in order.
//   the base is first reduced by a bit-serial shift-subtract pass. each
//   exponent bit then takes a modular square, preceded by a modular
//   product when the bit is set, on a single shared bit-serial
//   shift-add-reduce multiplier.
//   exponent is scanned until its remaining bits are zero.
//   a zero modulus or zero exponent skips the reduction and goes straight
//   to the done state. one request is worked on at a time.
//   the result sits in an output register until taken; the next request is
//   accepted no earlier than the cycle the result is taken, so a stalled
//   receiver holds only the finished result and the next request waits at
//   in_ready.
//   synchronous active-low reset returns the block to idle and drops any
//   pending result; nothing is kept between requests.
// ----------------------------------------------------------------------------
module modular_exponentiation (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mexp_pkg::FIELD_W-1:0] in_base,
  input  logic [mexp_pkg::FIELD_W-1:0] in_exponent,
  input  logic [mexp_pkg::FIELD_W-1:0] in_modulus,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mexp_pkg::FIELD_W-1:0] out_power_result,
  output logic                        out_modulus_zero_error
);
  localparam int unsigned W = mexp_pkg::WIDTH;

  typedef enum logic [2:0] {
    S_IDLE, S_RED, S_NEXT, S_MUL, S_SQR, S_DONE
  } state_t;

  state_t            state_r;
  mexp_pkg::word_t   m_r, e_r, acc_r, sq_r, x_r, y_r, p_r;
  mexp_pkg::cnt_t    cnt_r;
  logic              res_valid_r, res_err_r;
  mexp_pkg::word_t   res_r;

  // one step of shared unit: p = 2p (+x) mod m, y shifts out msb first
  logic [W:0]        dbl, dsub, addv, asub;
  mexp_pkg::word_t   p_dbl, p_step;
  always_comb begin
    dbl   = {p_r, 1'b0};
    dsub  = dbl - {1'b0, m_r};
    p_dbl = dsub[W] ? dbl[W-1:0] : dsub[W-1:0];
    addv  = {1'b0, p_dbl} + {1'b0, x_r};
    asub  = addv - {1'b0, m_r};
    p_step = y_r[W-1] ? (asub[W] ? addv[W-1:0] : asub[W-1:0]) : p_dbl;
  end

  // reduction step: shift base bit into remainder, subtract if possible
  logic [W:0]        rsh, rsub;
  always_comb begin
    rsh  = {p_r, y_r[W-1]};
    rsub = rsh - {1'b0, m_r};
  end

  assign in_ready = (state_r == S_IDLE) && !(res_valid_r && !out_ready);
  assign out_valid = res_valid_r;
  assign out_power_result = mexp_pkg::FIELD_W'(res_r);
  assign out_modulus_zero_error = res_err_r;

  mexp_pkg::word_t one_mod;
  assign one_mod = (m_r == mexp_pkg::word_t'(1)) ? '0 : mexp_pkg::word_t'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      if (res_valid_r && out_ready) res_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            m_r <= in_modulus[W-1:0];
            e_r <= in_exponent[W-1:0];
            y_r <= in_base[W-1:0];
            p_r <= '0;
            cnt_r <= '0;
            if (in_modulus[W-1:0] == '0) begin
              res_r <= '0; res_err_r <= 1'b1; state_r <= S_DONE;
            end else if (in_exponent[W-1:0] == '0) begin
              res_r <= mexp_pkg::word_t'(1); res_err_r <= 1'b0; state_r <= S_DONE;
            end else begin
              state_r <= S_RED;
            end
          end
        end
        S_RED: begin
          p_r <= (rsh >= {1'b0, m_r}) ? rsub[W-1:0] : rsh[W-1:0];
          y_r <= {y_r[W-2:0], 1'b0};
          if (cnt_r == mexp_pkg::cnt_t'(W - 1)) begin
            state_r <= S_NEXT;
            acc_r <= one_mod;
          end
          cnt_r <= cnt_r + 1'b1;
        end
        S_NEXT: begin
          if (cnt_r == mexp_pkg::cnt_t'(W)) sq_r <= p_r;
          else if (e_r[0]) acc_r <= p_r;
          else sq_r <= p_r;
          cnt_r <= '0;
          p_r <= '0;
          if (cnt_r == mexp_pkg::cnt_t'(W) || !e_r[0]) begin
            // after squaring: shift exponent
            if (cnt_r != mexp_pkg::cnt_t'(W)) begin
              e_r <= e_r >> 1;
              if ((e_r >> 1) == '0) begin
                res_r <= acc_r; res_err_r <= 1'b0; state_r <= S_DONE;
              end else begin
                x_r <= sq_r; y_r <= sq_r; state_r <= S_SQR;
              end
            end else if (e_r[0]) begin
              x_r <= acc_r; y_r <= p_r; state_r <= S_MUL;
            end else begin
              x_r <= p_r; y_r <= p_r; state_r <= S_SQR;
            end
          end else begin
            x_r <= p_r; y_r <= sq_r; state_r <= S_SQR;
          end
        end
        S_MUL, S_SQR: begin
          p_r <= p_step;
          y_r <= {y_r[W-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == mexp_pkg::cnt_t'(W - 1)) begin
            if (state_r == S_MUL) begin
              acc_r <= p_step;
              x_r <= sq_r; y_r <= sq_r; p_r <= '0; cnt_r <= '0;
              state_r <= S_SQR;
            end else begin
              sq_r <= p_step;
              e_r <= e_r >> 1;
              cnt_r <= '0; p_r <= '0;
              if ((e_r >> 1) == '0) begin
                res_r <= acc_r; res_err_r <= 1'b0; state_r <= S_DONE;
              end else if (e_r[1]) begin
                x_r <= acc_r; y_r <= p_step; state_r <= S_MUL;
              end else begin
                x_r <= p_step; y_r <= p_step; state_r <= S_SQR;
              end
            end
          end
        end
        S_DONE: begin
          if (!res_valid_r) begin
            res_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_modulus_zero_error |-> out_power_result == '0)
    else $error("error result not zero");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE)
    else $error("ready outside idle");
  a_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_SQR) |-> p_r < m_r)
    else $error("partial product not reduced");
`endif
endmodule

/* test/modular_exponentiation_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// Drives base, exponent and modulus requests into the modular exponentiation
// block and checks each result against a square-and-multiply predictor. It
// covers directed edge cases from a stimulus table, then random requests,
// with random gaps on both channels and one long receiver stall.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;

  localparam int unsigned N_RANDOM = 84;
  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam int unsigned N_DIRECTED = 16;
  localparam int unsigned HOLD_CYCLES = 20000;

  typedef logic [mexp_pkg::FIELD_W-1:0] field_t;

  typedef struct packed {
    field_t power_result;
    logic   modulus_zero_error;
  } power_t;

  typedef struct packed {
    field_t base;
    field_t exponent;
    field_t modulus;
    logic   fixed;
    power_t result;
  } request_row_t;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  field_t in_base;
  field_t in_exponent;
  field_t in_modulus;
  logic   out_valid;
  logic   out_ready;
  field_t out_power_result;
  logic   out_modulus_zero_error;

  power_t power_q[$];
  int     n_errors;
  int     idle_cycles;
  bit     sending_done;
  bit     hold_receiver;
  bit     timed_out;

  modular_exponentiation i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_base               (in_base),
    .in_exponent           (in_exponent),
    .in_modulus            (in_modulus),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_power_result      (out_power_result),
    .out_modulus_zero_error(out_modulus_zero_error)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic mexp_pkg::word_t mulmod(mexp_pkg::word_t x, mexp_pkg::word_t y,
                                             mexp_pkg::word_t m);
    logic [mexp_pkg::WIDTH:0] acc;
    acc = '0;
    for (int i = mexp_pkg::WIDTH - 1; i >= 0; i--) begin
      acc = acc << 1;
      if (acc >= m) acc = acc - m;
      if (y[i]) begin
        acc = acc + x;
        if (acc >= m) acc = acc - m;
      end
    end
    return acc[mexp_pkg::WIDTH-1:0];
  endfunction

  function automatic power_t predict_power(field_t b_in, field_t e_in, field_t m_in);
    power_t          r;
    mexp_pkg::word_t b;
    mexp_pkg::word_t e;
    mexp_pkg::word_t m;
    mexp_pkg::word_t acc;
    mexp_pkg::word_t sq;
    b = b_in[mexp_pkg::WIDTH-1:0];
    e = e_in[mexp_pkg::WIDTH-1:0];
    m = m_in[mexp_pkg::WIDTH-1:0];
    r = '0;
    if (m == '0) begin
      r.modulus_zero_error = 1'b1;
    end else if (e == '0) begin
      r.power_result = field_t'(1);
    end else begin
      acc = (m == mexp_pkg::word_t'(1)) ? '0 : mexp_pkg::word_t'(1);
      sq = b % m;
      while (e != '0) begin
        if (e[0]) acc = mulmod(acc, sq, m);
        sq = mulmod(sq, sq, m);
        e = e >> 1;
      end
      r.power_result = field_t'(acc);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, field_t got, field_t want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    n_errors++;
  endtask

  function automatic field_t rand_field();
    field_t v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = v >> $urandom_range(0, 63);
      1: v = field_t'($urandom_range(0, 20));
      2: v = ~field_t'($urandom_range(0, 20));
      default: ;
    endcase
    return v;
  endfunction

  function automatic int rand_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  task automatic send_request(field_t b, field_t e, field_t m, bit fixed, power_t want);
    power_t p;
    in_base = b;
    in_exponent = e;
    in_modulus = m;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = predict_power(b, e, m);
    if (fixed && p != want) begin
      report_mismatch("table row", field_t'(want.power_result), field_t'(p.power_result));
    end
    power_q.push_back(p);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  request_row_t directed_rows[N_DIRECTED];

  initial begin
    directed_rows[0]  = '{'0, '0, '0, 1'b1, '{'0, 1'b1}};
    directed_rows[1]  = '{64'd5, 64'd7, '0, 1'b1, '{'0, 1'b1}};
    directed_rows[2]  = '{64'd5, '0, 64'd1, 1'b1, '{64'd1, 1'b0}};
    directed_rows[3]  = '{'1, '0, '1, 1'b1, '{64'd1, 1'b0}};
    directed_rows[4]  = '{64'd5, 64'd3, 64'd1, 1'b1, '{'0, 1'b0}};
    directed_rows[5]  = '{64'd2, 64'd10, 64'd1000, 1'b1, '{64'd24, 1'b0}};
    directed_rows[6]  = '{'0, 64'd9, 64'd13, 1'b1, '{'0, 1'b0}};
    directed_rows[7]  = '{64'd3, 64'd1, 64'd7, 1'b1, '{64'd3, 1'b0}};
    directed_rows[8]  = '{64'd10, 64'd1, 64'd7, 1'b1, '{64'd3, 1'b0}};
    directed_rows[9]  = '{'1, '1, '1, 1'b0, '0};
    directed_rows[10] = '{'1, 64'd2, '1, 1'b0, '0};
    directed_rows[11] = '{'1, '1, 64'd2, 1'b1, '{64'd1, 1'b0}};
    directed_rows[12] = '{64'h8000_0000_0000_0000, '1, '1, 1'b0, '0};
    directed_rows[13] = '{64'h1234_5678_9abc_def0, 64'h8000_0000_0000_0001,
                          64'hffff_ffff_ffff_ffc5, 1'b0, '0};
    directed_rows[14] = '{64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                          64'h7fff_ffff_ffff_ffff, 1'b0, '0};
    directed_rows[15] = '{64'h7, 64'h7fff_ffff_ffff_ffff, 64'd1000003, 1'b0, '0};
  end

  // sender
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_base = '0;
    in_exponent = '0;
    in_modulus = '0;
    sending_done = 1'b0;
    hold_receiver = 1'b0;
    n_errors = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].base, directed_rows[i].exponent,
                   directed_rows[i].modulus, directed_rows[i].fixed,
                   directed_rows[i].result);
      repeat (rand_gap()) @(negedge clk);
    end
    // pause until drained
    while (power_q.size() != 0) @(negedge clk);
    hold_receiver = 1'b1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i >= 40 && i < 60) begin
        send_request(rand_field(), field_t'($urandom_range(0, 255)), rand_field(), 1'b0, '0);
      end else begin
        send_request(rand_field(), rand_field(), rand_field(), 1'b0, '0);
      end
      if (i % 3 == 0) repeat (rand_gap()) @(negedge clk);
    end
    sending_done = 1'b1;
  end

  // receiver
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_receiver) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_receiver = 1'b0;
      end
      if ($urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat (rand_gap()) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    power_t want;
    if (rst_n && out_valid && out_ready) begin
      if (power_q.size() == 0) begin
        $display("unexpected result %h", out_power_result);
        n_errors++;
      end else begin
        want = power_q.pop_front();
        if (out_power_result !== want.power_result)
          report_mismatch("power_result", out_power_result, want.power_result);
        if (out_modulus_zero_error !== want.modulus_zero_error)
          report_mismatch("modulus_zero_error", field_t'(out_modulus_zero_error),
                          field_t'(want.modulus_zero_error));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    timed_out = 1'b0;
    @(posedge rst_n);
    while (!(sending_done && power_q.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      timed_out = 1'b1;
    end else begin
      repeat (50) @(posedge clk);
    end
    if (timed_out) begin
      $display("timeout");
      $display("Verification failed");
    end else if (n_errors == 0 && power_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
